FILE: src/srg_pkg.sv
// Shared widths, codes and constants of the stepper ramp generator.
package srg_pkg;

  localparam int POSITION_BITS = 24;
  localparam int FRACTION_BITS = 16;
  localparam int PER_W = 20;
  localparam int REG_W = 16;
  localparam int ELAPSED_W = 24;

  localparam int MUL_W = 38;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W = 56;
  localparam int DSR_W = 38;
  localparam int CNT_W = 6;

  localparam logic [DVD_W-1:0] US_PER_S = DVD_W'(1000000);
  localparam logic [DVD_W-1:0] ONE_Q = US_PER_S << FRACTION_BITS;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [1:0] REG_MAX_VEL = 2'd0;
  localparam logic [1:0] REG_MIN_VEL = 2'd1;
  localparam logic [1:0] REG_MAX_ACC = 2'd2;
  localparam logic [1:0] REG_MARGIN = 2'd3;

endpackage

FILE: src/srg_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module srg_mul
  import srg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_W-1:0]  a_r;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MUL_W:0]    sum;

  always_comb begin
    sum = {1'b0, prod_r[PROD_W-1:MUL_W]} + (prod_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r <= a;
        prod_r <= {{MUL_W{1'b0}}, b};
        cnt_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        prod_r <= {sum, prod_r[MUL_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

FILE: src/srg_div.sv
// Restoring serial divider, one quotient bit per cycle.
module srg_div
  import srg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    diff = rem_sh - {1'b0, dsr_r};
    qbit = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        dsr_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

FILE: src/stepper_ramp_generator_core.sv
// Top level of the stepper ramp generator: sequencer, state and item ports.
// A start item that begins a move shows its result after one 56-step serial division; other
// starts, stops, finishing items and idle items go straight to the push state. A tick of a
// moving motor that has not finished runs two or three 56-step divisions and up to four 38-step
// multiplications, one bit per cycle in the shared units. The push state waits while the result
// port is stalled, and the next item is taken once the result is pushed.
// One item is worked at a time. Synchronous reset clears the ramp state and loads default rates.
module stepper_ramp_generator_core
  import srg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // target_step[23:0], step_count[47:24], move_done[48], elapsed_us[72:49], zero fill
  input  logic [79:0]      in_tdata,
  // kind[1:0]
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // step_period_us[19:0], moving[20], decelerating[21], zero fill
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_START_DIV, S_VQ, S_AE, S_DVEL, S_LHS, S_PROD, S_DECIDE, S_PMUL, S_FDIV, S_PUSH
  } state_t;

  state_t state_r;
  logic [REG_W-1:0] max_vel_r, min_vel_r, acc_r, margin_r;
  logic moving_r, braking_r, fin_r;
  logic [PER_W-1:0] period_r;
  logic [POSITION_BITS-1:0] goal_r, pos_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [MUL_W-1:0] vq_r, dvel_r;
  logic [PROD_W-1:0] lhs_r;
  logic out_valid_r, out_fin_r, out_mov_r, out_dec_r;
  logic [PER_W-1:0] out_per_r;
  logic mul_go_r, div_go_r;
  logic [MUL_W-1:0] mul_a_r, mul_b_r;
  logic [DVD_W-1:0] div_dvd_r;
  logic [DSR_W-1:0] div_dsr_r;

  logic mul_done, div_done;
  logic [PROD_W-1:0] mul_prod;
  logic [DVD_W-1:0] div_quot;

  logic [REG_W-1:0] vmin_nz, vmax_nz, acc_nz;
  logic [PER_W-1:0] per_nz;
  logic [MUL_W-1:0] vmin_q, vmax_q, nv_brake, nv_run, vsum, adv;
  logic [MUL_W:0] dv;
  logic [POSITION_BITS:0] diff, absd;
  logic [POSITION_BITS+1:0] rem_dist;
  logic [POSITION_BITS:0] ar;
  logic below;
  logic in_acc;
  logic push_ok;

  srg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .prod(mul_prod)
  );

  srg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .dividend(div_dvd_r), .divisor(div_dsr_r),
    .done(div_done), .quot(div_quot)
  );

  always_comb begin
    vmin_nz = (min_vel_r == '0) ? REG_W'(1) : min_vel_r;
    vmax_nz = (max_vel_r == '0) ? REG_W'(1) : max_vel_r;
    acc_nz = (acc_r == '0) ? REG_W'(1) : acc_r;
    per_nz = (period_r == '0) ? PER_W'(1) : period_r;
    vmin_q = MUL_W'({vmin_nz, {FRACTION_BITS{1'b0}}});
    vmax_q = MUL_W'({vmax_nz, {FRACTION_BITS{1'b0}}});
    nv_brake = (vq_r > dvel_r) ? (vq_r - dvel_r) : '0;
    nv_run = vq_r + dvel_r;
    vsum = vq_r + vmin_q;
    dv = {1'b0, vq_r} - {1'b0, vmin_q};
    adv = dv[MUL_W] ? MUL_W'(-dv) : dv[MUL_W-1:0];
    diff = {goal_r[POSITION_BITS-1], goal_r} - {pos_r[POSITION_BITS-1], pos_r};
    absd = diff[POSITION_BITS] ? -diff : diff;
    rem_dist = {1'b0, absd} - (POSITION_BITS+2)'(margin_r);
    ar = rem_dist[POSITION_BITS+1] ? (POSITION_BITS+1)'(-rem_dist)
                                   : rem_dist[POSITION_BITS:0];
    if (rem_dist[POSITION_BITS+1]) begin
      below = !dv[MUL_W] || (lhs_r > mul_prod);
    end else begin
      below = !dv[MUL_W] && (dv != '0) && (lhs_r < mul_prod);
    end
    in_acc = in_tvalid && (state_r == S_IDLE);
    push_ok = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_vel_r <= REG_W'(1000);
      min_vel_r <= REG_W'(100);
      acc_r <= REG_W'(500);
      margin_r <= '0;
      moving_r <= 1'b0;
      braking_r <= 1'b0;
      period_r <= '0;
      goal_r <= '0;
      fin_r <= 1'b0;
      out_valid_r <= 1'b0;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (out_valid_r && out_tready && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_addr)
          REG_MAX_VEL: max_vel_r <= cfg_data;
          REG_MIN_VEL: min_vel_r <= cfg_data;
          REG_MAX_ACC: acc_r <= cfg_data;
          REG_MARGIN: margin_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pos_r <= in_tdata[47:24];
            elapsed_r <= in_tdata[72:49];
            fin_r <= 1'b0;
            state_r <= S_PUSH;
            case (in_tuser)
              KIND_START: begin
                goal_r <= in_tdata[23:0];
                if (!moving_r) begin
                  div_dvd_r <= US_PER_S;
                  div_dsr_r <= DSR_W'(vmin_nz);
                  div_go_r <= 1'b1;
                  state_r <= S_START_DIV;
                end
              end
              KIND_STOP: begin
                period_r <= '0;
                moving_r <= 1'b0;
                braking_r <= 1'b0;
              end
              KIND_TICK: begin
                if (moving_r) begin
                  if (in_tdata[48]) begin
                    period_r <= '0;
                    moving_r <= 1'b0;
                    braking_r <= 1'b0;
                    fin_r <= 1'b1;
                  end else begin
                    div_dvd_r <= ONE_Q;
                    div_dsr_r <= DSR_W'(per_nz);
                    div_go_r <= 1'b1;
                    state_r <= S_VQ;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_START_DIV: begin
          if (div_done) begin
            period_r <= div_quot[PER_W-1:0];
            moving_r <= 1'b1;
            braking_r <= 1'b0;
            state_r <= S_PUSH;
          end
        end
        S_VQ: begin
          if (div_done) begin
            vq_r <= div_quot[MUL_W-1:0];
            mul_a_r <= MUL_W'(acc_nz);
            mul_b_r <= MUL_W'(elapsed_r);
            mul_go_r <= 1'b1;
            state_r <= S_AE;
          end
        end
        S_AE: begin
          if (mul_done) begin
            div_dvd_r <= {mul_prod[DVD_W-FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}};
            div_dsr_r <= DSR_W'(US_PER_S);
            div_go_r <= 1'b1;
            state_r <= S_DVEL;
          end
        end
        S_DVEL: begin
          if (div_done) begin
            dvel_r <= div_quot[MUL_W-1:0];
            if (!braking_r) begin
              mul_a_r <= MUL_W'(acc_nz);
              mul_b_r <= MUL_W'(ar);
              mul_go_r <= 1'b1;
              state_r <= S_LHS;
            end else begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_LHS: begin
          if (mul_done) begin
            lhs_r <= {mul_prod[PROD_W-34:0], 33'b0};
            mul_a_r <= vsum;
            mul_b_r <= adv;
            mul_go_r <= 1'b1;
            state_r <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul_done) begin
            if (below) begin
              braking_r <= 1'b1;
            end
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (braking_r) begin
            if (nv_brake > vmin_q) begin
              div_dvd_r <= ONE_Q;
              div_dsr_r <= nv_brake;
            end else begin
              div_dvd_r <= US_PER_S;
              div_dsr_r <= DSR_W'(vmin_nz);
            end
            div_go_r <= 1'b1;
            state_r <= S_FDIV;
          end else begin
            mul_a_r <= MUL_W'(per_nz);
            mul_b_r <= MUL_W'(vmax_nz);
            mul_go_r <= 1'b1;
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            if (mul_prod > PROD_W'(US_PER_S)) begin
              if (nv_run < vmax_q) begin
                div_dvd_r <= ONE_Q;
                div_dsr_r <= nv_run;
              end else begin
                div_dvd_r <= US_PER_S;
                div_dsr_r <= DSR_W'(vmax_nz);
              end
              div_go_r <= 1'b1;
              state_r <= S_FDIV;
            end else begin
              state_r <= S_PUSH;
            end
          end
        end
        S_FDIV: begin
          if (div_done) begin
            period_r <= div_quot[PER_W-1:0];
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            out_valid_r <= 1'b1;
            out_per_r <= period_r;
            out_mov_r <= moving_r;
            out_dec_r <= braking_r;
            out_fin_r <= fin_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_dec_r, out_mov_r, out_per_r};
  assign out_tlast = out_fin_r;

endmodule

FILE: src/srg_checker.sv
// Port-level checks of the stepper ramp generator result channel, bound to the top level.
module srg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_finish_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[19:0] == 20'd0 && !out_tdata[20] && !out_tdata[21])
    else $error("finishing item does not show a halted motor");

  a_brake_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[20])
    else $error("braking shown without a move in progress");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[20] |-> out_tdata[19:0] == 20'd0)
    else $error("non-zero period while not moving");

endmodule

bind stepper_ramp_generator_core srg_checker u_srg_checker (.*);
